// File: rtl/core/drqc_pkg.sv
`default_nettype none
package drqc_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] CFG_BATCH     = 2'd0;
    localparam logic [1:0] CFG_SNAP_LEN  = 2'd1;
    localparam logic [1:0] CFG_SNAP_ADDR = 2'd2;

    localparam logic [0:0] KIND_READ  = 1'b0;
    localparam logic [0:0] KIND_CLEAN = 1'b1;

    typedef struct packed {
        logic clearing;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic makes_result;
        logic out_blocked;
    } ctrl_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/drqc_ram.sv
`default_nettype none
module drqc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/drqc_ctrl.sv
`default_nettype none
module drqc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire drqc_pkg::ctrl_sts_t  sts,
    output drqc_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd.clearing = (state_reg == ST_CLEAR);
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.commit   = (state_reg == ST_EXEC) && !(sts.makes_result && sts.out_blocked);
        s_tready     = (state_reg == ST_IDLE);
        state_next   = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/drqc_datapath.sv
`default_nettype none
module drqc_datapath #(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire drqc_pkg::ctrl_cmd_t  cmd,
    output drqc_pkg::ctrl_sts_t       sts,
    input  wire logic [95:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [135:0]              m_tdata,
    output logic [0:0]                m_tuser,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [63:0]          pwdata,
    output logic [63:0]               prdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [29:0] OFS_RQ_HEAD   = 30'd0;
    localparam logic [29:0] OFS_RQ_TAIL   = 30'd8;
    localparam logic [29:0] OFS_RQ_TAIL4  = 30'd12;
    localparam logic [29:0] OFS_DOORBELL  = 30'(16 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_BUSY      = 30'(24 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_HEAD   = 30'(32 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_HEAD4  = 30'(36 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_TAIL   = 30'(40 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_TAIL4  = 30'(44 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_BASE   = 30'(48 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_CQ_BASE4  = 30'(52 + 8 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_BATCH     = 30'(48 + 16 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_DEPTH     = 30'(56 + 16 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_SNAP_LEN  = 30'(64 + 16 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_SNAP_ADDR = 30'(72 + 16 * QUEUE_DEPTH);
    localparam logic [29:0] OFS_SNAP_ADR4 = 30'(76 + 16 * QUEUE_DEPTH);
    localparam logic [63:0] DEPTH_VAL     = 64'(QUEUE_DEPTH);

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    logic [31:0]   batch_reg, batch_next;
    logic [31:0]   snap_len_reg, snap_len_next;
    logic [63:0]   snap_addr_reg, snap_addr_next;
    logic [AW-1:0] rq_head_reg, rq_head_next, rq_tail_reg, rq_tail_next;
    logic [AW-1:0] cq_head_reg, cq_head_next, cq_tail_reg, cq_tail_next;
    logic          armed_reg, armed_next, busy_reg, busy_next;
    logic          pass_reg, pass_next;
    logic [63:0]   pop_hold_reg, pop_hold_next, push_hold_reg, push_hold_next;
    logic [31:0]   count_reg, count_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [1:0]    func_reg;
    logic [29:0]   ofs_reg;
    logic [63:0]   data_reg;
    logic          m_valid_reg;
    logic [0:0]    m_kind_reg;
    logic [63:0]   m_rdata_reg, m_addr_reg;
    logic          m_irq_reg, m_drop_reg;
    logic [63:0]   res_rdata;
    logic          res_irq, res_drop;
    logic          makes_result;

    logic          rq_we, cq_we, rq_we_x, cq_we_x;
    logic [AW-1:0] rq_waddr, cq_waddr, rq_waddr_x, cq_waddr_x, rq_raddr, cq_raddr;
    logic [63:0]   rq_wdata, cq_wdata, rq_wdata_x, cq_wdata_x, rq_q, cq_q;
    logic [29:0]   in_ofs;
    logic [1:0]    in_func;
    logic [63:0]   ph;
    logic [31:0]   cnt_inc;
    logic          apb_wr;
    logic          cfg_batch_wr, cfg_len_wr, cfg_addr_wr;

    assign in_ofs  = s_tdata[29:0];
    assign in_func = s_tuser;
    assign apb_wr  = psel && penable && pwrite;

    always_comb begin
        rq_raddr = (in_func == drqc_pkg::FUNC_TICK) ? rq_head_reg : rq_tail_reg;
        if (in_func == drqc_pkg::FUNC_TICK) begin
            cq_raddr = cq_tail_reg;
        end else if (in_ofs == OFS_CQ_BASE || in_ofs == OFS_CQ_BASE4) begin
            cq_raddr = '0;
        end else begin
            cq_raddr = cq_head_reg;
        end
    end

    drqc_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_ready_ring (
        .aclk(aclk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
        .re(cmd.accept), .raddr(rq_raddr), .rdata(rq_q)
    );

    drqc_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_done_ring (
        .aclk(aclk), .we(cq_we), .waddr(cq_waddr), .wdata(cq_wdata),
        .re(cmd.accept), .raddr(cq_raddr), .rdata(cq_q)
    );

    always_comb begin
        rq_we    = cmd.clearing || (cmd.commit && rq_we_x);
        cq_we    = cmd.clearing || (cmd.commit && cq_we_x);
        rq_waddr = cmd.clearing ? clr_cnt_reg : rq_waddr_x;
        cq_waddr = cmd.clearing ? clr_cnt_reg : cq_waddr_x;
        rq_wdata = cmd.clearing ? 64'd0 : rq_wdata_x;
        cq_wdata = cmd.clearing ? 64'd0 : cq_wdata_x;
    end

    always_comb begin
        cfg_batch_wr = 1'b0;
        cfg_len_wr   = 1'b0;
        cfg_addr_wr  = 1'b0;
        if (apb_wr) begin
            unique case (paddr[4:3])
                drqc_pkg::CFG_BATCH:     cfg_batch_wr = 1'b1;
                drqc_pkg::CFG_SNAP_LEN:  cfg_len_wr = 1'b1;
                drqc_pkg::CFG_SNAP_ADDR: cfg_addr_wr = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        batch_next     = batch_reg;
        snap_len_next  = snap_len_reg;
        snap_addr_next = snap_addr_reg;
        rq_head_next   = rq_head_reg;
        rq_tail_next   = rq_tail_reg;
        cq_head_next   = cq_head_reg;
        cq_tail_next   = cq_tail_reg;
        armed_next     = armed_reg;
        busy_next      = busy_reg;
        pass_next      = pass_reg;
        pop_hold_next  = pop_hold_reg;
        push_hold_next = push_hold_reg;
        count_next     = count_reg;
        rq_we_x        = 1'b0;
        cq_we_x        = 1'b0;
        rq_waddr_x     = rq_head_reg;
        cq_waddr_x     = cq_head_reg;
        rq_wdata_x     = 64'd0;
        cq_wdata_x     = 64'd0;
        res_rdata      = '1;
        res_irq        = 1'b0;
        res_drop       = 1'b0;
        makes_result   = 1'b0;
        ph             = (data_reg << 32) | push_hold_reg;
        cnt_inc        = count_reg + 32'd1;
        unique case (func_reg)
            drqc_pkg::FUNC_READ: begin
                makes_result = 1'b1;
                unique case (ofs_reg)
                    OFS_CQ_BASE:  res_rdata = cq_q;
                    OFS_CQ_BASE4: res_rdata = cq_q >> 32;
                    OFS_CQ_HEAD: begin
                        res_rdata     = cq_q;
                        pop_hold_next = cq_q;
                        if (cq_tail_reg != cq_head_reg || cq_q != 64'd0) begin
                            cq_we_x      = 1'b1;
                            cq_head_next = advance(cq_head_reg);
                        end
                    end
                    OFS_CQ_HEAD4: begin
                        res_rdata     = pop_hold_reg >> 32;
                        pop_hold_next = 64'd0;
                    end
                    OFS_CQ_TAIL:   res_rdata = 64'(cq_tail_reg);
                    OFS_CQ_TAIL4:  res_rdata = 64'd0;
                    OFS_BUSY:      res_rdata = 64'(busy_reg);
                    OFS_BATCH:     res_rdata = 64'(batch_reg);
                    OFS_DOORBELL:  res_rdata = 64'(armed_reg);
                    OFS_DEPTH:     res_rdata = DEPTH_VAL;
                    OFS_SNAP_LEN:  res_rdata = 64'(snap_len_reg);
                    OFS_SNAP_ADDR: res_rdata = snap_addr_reg;
                    OFS_SNAP_ADR4: res_rdata = snap_addr_reg >> 32;
                    default:       res_rdata = '1;
                endcase
            end
            drqc_pkg::FUNC_WRITE: begin
                unique case (ofs_reg)
                    OFS_RQ_TAIL: push_hold_next = data_reg;
                    OFS_RQ_TAIL4: begin
                        push_hold_next = ph;
                        if (rq_head_reg != rq_tail_reg || rq_q == 64'd0) begin
                            rq_we_x      = 1'b1;
                            rq_waddr_x   = rq_tail_reg;
                            rq_wdata_x   = ph;
                            rq_tail_next = advance(rq_tail_reg);
                        end
                    end
                    OFS_BATCH:     batch_next = data_reg[31:0];
                    OFS_DOORBELL:  armed_next = 1'b1;
                    OFS_SNAP_LEN:  snap_len_next = data_reg[31:0];
                    OFS_SNAP_ADDR: snap_addr_next = data_reg;
                    OFS_SNAP_ADR4: snap_addr_next = (data_reg << 32) | snap_addr_reg;
                    default: ;
                endcase
            end
            drqc_pkg::FUNC_TICK: begin
                if (pass_reg || armed_reg) begin
                    if (!pass_reg) begin
                        busy_next  = 1'b1;
                        armed_next = 1'b0;
                        pass_next  = 1'b1;
                    end
                    if (rq_tail_reg != rq_head_reg || rq_q != 64'd0) begin
                        rq_we_x      = 1'b1;
                        rq_head_next = advance(rq_head_reg);
                    end
                    if (rq_q == 64'd0) begin
                        pass_next = 1'b0;
                    end else begin
                        makes_result = 1'b1;
                        res_rdata    = 64'd0;
                        busy_next    = 1'b0;
                        if (cq_head_reg != cq_tail_reg || cq_q == 64'd0) begin
                            cq_we_x      = 1'b1;
                            cq_waddr_x   = cq_tail_reg;
                            cq_wdata_x   = rq_q;
                            cq_tail_next = advance(cq_tail_reg);
                        end else begin
                            res_drop = 1'b1;
                        end
                        if (cnt_inc >= batch_reg) begin
                            res_irq    = 1'b1;
                            count_next = 32'd0;
                        end else begin
                            count_next = cnt_inc;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign sts.clear_done   = (clr_cnt_reg == LAST_IDX);
    assign sts.makes_result = makes_result;
    assign sts.out_blocked  = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_reg     <= 32'd1;
            snap_len_reg  <= 32'd8;
            snap_addr_reg <= 64'd0;
            rq_head_reg   <= '0;
            rq_tail_reg   <= '0;
            cq_head_reg   <= '0;
            cq_tail_reg   <= '0;
            armed_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            pass_reg      <= 1'b0;
            pop_hold_reg  <= 64'd0;
            push_hold_reg <= 64'd0;
            count_reg     <= 32'd0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clearing && !sts.clear_done) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.commit && makes_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_batch_wr) begin
                batch_reg <= pwdata[31:0];
            end else if (cmd.commit) begin
                batch_reg <= batch_next;
            end
            if (cfg_len_wr) begin
                snap_len_reg <= pwdata[31:0];
            end else if (cmd.commit) begin
                snap_len_reg <= snap_len_next;
            end
            if (cfg_addr_wr) begin
                snap_addr_reg <= pwdata;
            end else if (cmd.commit) begin
                snap_addr_reg <= snap_addr_next;
            end
            if (cmd.commit) begin
                rq_head_reg   <= rq_head_next;
                rq_tail_reg   <= rq_tail_next;
                cq_head_reg   <= cq_head_next;
                cq_tail_reg   <= cq_tail_next;
                armed_reg     <= armed_next;
                busy_reg      <= busy_next;
                pass_reg      <= pass_next;
                pop_hold_reg  <= pop_hold_next;
                push_hold_reg <= push_hold_next;
                count_reg     <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= in_func;
            ofs_reg  <= in_ofs;
            data_reg <= s_tdata[93:30];
        end
        if (cmd.commit && makes_result) begin
            m_kind_reg  <= (func_reg == drqc_pkg::FUNC_TICK) ? drqc_pkg::KIND_CLEAN
                                                            : drqc_pkg::KIND_READ;
            m_rdata_reg <= res_rdata;
            m_addr_reg  <= (func_reg == drqc_pkg::FUNC_TICK) ? rq_q : 64'd0;
            m_irq_reg   <= res_irq;
            m_drop_reg  <= res_drop;
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            drqc_pkg::CFG_BATCH:     prdata = 64'(batch_reg);
            drqc_pkg::CFG_SNAP_LEN:  prdata = 64'(snap_len_reg);
            drqc_pkg::CFG_SNAP_ADDR: prdata = snap_addr_reg;
            default:                 prdata = 64'd0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {6'd0, m_drop_reg, m_irq_reg, m_addr_reg, m_rdata_reg};

    a_clean_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == drqc_pkg::KIND_CLEAN |-> m_addr_reg != 64'd0)
        else $error("cleaned address of zero delivered");

    a_read_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_kind_reg == drqc_pkg::KIND_READ |-> !m_irq_reg && !m_drop_reg)
        else $error("flags set on a read result");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && makes_result |-> !(m_valid_reg && !m_tready))
        else $error("result register overwritten while stalled");

    a_no_commit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clearing |-> !cmd.commit && !cmd.accept)
        else $error("item handled during ring clearing");

endmodule
`default_nettype wire

// File: rtl/core/doorbell_ring_queue_cleaner.sv
// Doorbell ring queue cleaner.
// Input items arrive on the s_ stream: tuser carries the function (bus read, bus write,
// engine tick) and tdata the byte offset and write data. Bus reads and ticks that clean
// an entry return one transaction on the m_ stream; tuser gives its kind and tdata the
// read data, cleaned address, interrupt and dropped flags. Writes and idle ticks return
// nothing.
// Each item has an accept step, which reads the ready and completion ring memories, and
// an update step, which writes them and the pointers. The result is loaded into the
// output register, raising m_tvalid, at the update edge, which a stalled receiver can
// delay. After reset both rings are zeroed by a clearing pass over every entry, during
// which s_tready stays low; configuration writes on the APB port are taken throughout.
// When the receiver stalls, the result waits in the output register; the next item is
// still accepted and read, and it is held before its update only if it too has a
// result to deliver.
`default_nettype none
module doorbell_ring_queue_cleaner #(
    parameter int QUEUE_DEPTH = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // byte_offset[29:0], write_data[93:30]
    input  wire logic [1:0]   s_tuser,  // func[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [135:0]      m_tdata,  // read_data[63:0], cleaned_address[127:64],
                                        // raise_interrupt[128], completion_dropped[129]
    output logic [0:0]        m_tuser,  // result_kind[0]
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    drqc_pkg::ctrl_cmd_t cmd;
    drqc_pkg::ctrl_sts_t sts;

    assign pready = 1'b1;

    drqc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    drqc_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata)
    );

endmodule
`default_nettype wire
